FILE: design/msgpk_pkg.sv
// ----------------------------------------------------------------------------
// msgpk_pkg
// Shared codes, tags and stage types for the MessagePack value header encoder.
// ----------------------------------------------------------------------------
package msgpk_pkg;

  // Item type codes on func_i
  localparam logic [3:0] FN_NIL   = 4'd0;
  localparam logic [3:0] FN_BOOL  = 4'd1;
  localparam logic [3:0] FN_UINT  = 4'd2;
  localparam logic [3:0] FN_SINT  = 4'd3;
  localparam logic [3:0] FN_F32   = 4'd4;
  localparam logic [3:0] FN_F64   = 4'd5;
  localparam logic [3:0] FN_STR   = 4'd6;
  localparam logic [3:0] FN_BIN   = 4'd7;
  localparam logic [3:0] FN_ARRAY = 4'd8;
  localparam logic [3:0] FN_MAP   = 4'd9;
  localparam logic [3:0] FN_TS    = 4'd10;
  localparam logic [3:0] FN_RAW   = 4'd11;

  // Format tags
  localparam logic [7:0] TAG_NIL    = 8'hC0;
  localparam logic [7:0] TAG_FALSE  = 8'hC2;
  localparam logic [7:0] TAG_TRUE   = 8'hC3;
  localparam logic [7:0] TAG_BIN8   = 8'hC4;
  localparam logic [7:0] TAG_BIN16  = 8'hC5;
  localparam logic [7:0] TAG_BIN32  = 8'hC6;
  localparam logic [7:0] TAG_EXT8   = 8'hC7;
  localparam logic [7:0] TAG_F32    = 8'hCA;
  localparam logic [7:0] TAG_F64    = 8'hCB;
  localparam logic [7:0] TAG_U8     = 8'hCC;
  localparam logic [7:0] TAG_U16    = 8'hCD;
  localparam logic [7:0] TAG_U32    = 8'hCE;
  localparam logic [7:0] TAG_U64    = 8'hCF;
  localparam logic [7:0] TAG_I8     = 8'hD0;
  localparam logic [7:0] TAG_I16    = 8'hD1;
  localparam logic [7:0] TAG_I32    = 8'hD2;
  localparam logic [7:0] TAG_I64    = 8'hD3;
  localparam logic [7:0] TAG_FIXEXT4 = 8'hD6;
  localparam logic [7:0] TAG_FIXEXT8 = 8'hD7;
  localparam logic [7:0] TAG_STR8   = 8'hD9;
  localparam logic [7:0] TAG_STR16  = 8'hDA;
  localparam logic [7:0] TAG_STR32  = 8'hDB;
  localparam logic [7:0] TAG_ARR16  = 8'hDC;
  localparam logic [7:0] TAG_ARR32  = 8'hDD;
  localparam logic [7:0] TAG_MAP16  = 8'hDE;
  localparam logic [7:0] TAG_MAP32  = 8'hDF;
  localparam logic [7:0] TAG_FIXSTR = 8'hA0;
  localparam logic [7:0] TAG_FIXARR = 8'h90;
  localparam logic [7:0] TAG_FIXMAP = 8'h80;
  localparam logic [7:0] TS_TYPE    = 8'hFF;
  localparam logic [7:0] TS96_LEN   = 8'h0C;

  // Longest encoding in bytes and the byte buffer width
  localparam int unsigned MaxBytes = 15;
  localparam int unsigned BufW     = MaxBytes * 8;

  // Range flags and fields after the classify stage
  typedef struct packed {
    logic [3:0]  func;
    logic [63:0] value;
    logic [31:0] ns;
    logic        u4;     // value < 16
    logic        u5;     // value < 32
    logic        u7;     // value < 128
    logic        u8;     // value fits 8 bits
    logic        u16;
    logic        u32;
    logic        s_fix;  // -32 .. 127
    logic        s8;
    logic        s16;
    logic        s32;
    logic        nz;
    logic        ts_small; // 32- or 64-bit timestamp form
    logic        ts_32;    // 32-bit timestamp form
  } msgpk_cls_t;

  // Packed encoding, left aligned
  typedef struct packed {
    logic [BufW-1:0] bytes;
    logic [3:0]      len;
    logic            err;
  } msgpk_enc_t;

endpackage

FILE: design/msgpack_value_header_encoder.sv
// ----------------------------------------------------------------------------
// msgpack_value_header_encoder
// The first byte of an item reaches the port after the classify, pack and
// shifter registers. Throughput: one item per cycle for one-byte encodings;
// an N-byte item (N up to 15) holds the output shifter, one byte per cycle.
// Reset clears the stage valid bits and the shifter count; the receiver
// cannot stall, so busy only reflects multi-byte items draining.
// ----------------------------------------------------------------------------
module msgpack_value_header_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func_i,
  input  logic [63:0] value_i,
  input  logic [31:0] nanoseconds_i,
  output logic        strobe_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        size_error_o
);
  import msgpk_pkg::*;

  logic       cls_valid, enc_valid;
  msgpk_cls_t cls;
  msgpk_enc_t enc;
  logic       ser_ready, enc_ready, cls_ready;

  // Stage enables: a stage advances when its successor has room
  assign enc_ready = !enc_valid || ser_ready;
  assign cls_ready = !cls_valid || enc_ready;
  assign busy      = !cls_ready;

  msgpk_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (cls_ready),
    .valid_i       (start),
    .func_i        (func_i),
    .value_i       (value_i),
    .nanoseconds_i (nanoseconds_i),
    .valid_o       (cls_valid),
    .cls_o         (cls)
  );

  msgpk_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (enc_ready),
    .valid_i (cls_valid),
    .cls_i   (cls),
    .valid_o (enc_valid),
    .enc_o   (enc)
  );

  msgpk_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (enc_valid),
    .enc_i        (enc),
    .ready_o      (ser_ready),
    .strobe_o     (strobe_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .size_error_o (size_error_o)
  );

  // Checks
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last without strobe");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_error_o |-> (last_o && out_byte_o == 8'h00))
    else $error("size error not a lone zero byte");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("gap inside an encoding");

  a_busy_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (cls_valid && enc_valid && !ser_ready))
    else $error("busy with a free stage");

endmodule

FILE: design/msgpk_classify.sv
// ----------------------------------------------------------------------------
// msgpk_classify
// First stage: registers the item and its range flags.
// ----------------------------------------------------------------------------
module msgpk_classify (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0]           func_i,
  input  logic [63:0]          value_i,
  input  logic [31:0]          nanoseconds_i,
  output logic                 valid_o,
  output msgpk_pkg::msgpk_cls_t cls_o
);
  import msgpk_pkg::*;

  logic       valid_q;
  msgpk_cls_t cls_d, cls_q;

  // Range checks on the raw fields
  always_comb begin
    cls_d          = '0;
    cls_d.func     = func_i;
    cls_d.value    = value_i;
    cls_d.ns       = nanoseconds_i;
    cls_d.u4       = (value_i[63:4] == '0);
    cls_d.u5       = (value_i[63:5] == '0);
    cls_d.u7       = (value_i[63:7] == '0);
    cls_d.u8       = (value_i[63:8] == '0);
    cls_d.u16      = (value_i[63:16] == '0);
    cls_d.u32      = (value_i[63:32] == '0);
    cls_d.s_fix    = (value_i[63:7] == '0) || (value_i[63:5] == '1);
    cls_d.s8       = (value_i[63:7] == '0) || (value_i[63:7] == '1);
    cls_d.s16      = (value_i[63:15] == '0) || (value_i[63:15] == '1);
    cls_d.s32      = (value_i[63:31] == '0) || (value_i[63:31] == '1);
    cls_d.nz       = (value_i != '0);
    cls_d.ts_small = (value_i[63:34] == '0) && (nanoseconds_i[31:30] == '0);
    cls_d.ts_32    = (value_i[63:32] == '0) && (nanoseconds_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;

endmodule

FILE: design/msgpk_pack.sv
// ----------------------------------------------------------------------------
// msgpk_pack
// Second stage: selects the format and lays out the bytes left aligned.
// ----------------------------------------------------------------------------
module msgpk_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  msgpk_pkg::msgpk_cls_t cls_i,
  output logic                  valid_o,
  output msgpk_pkg::msgpk_enc_t enc_o
);
  import msgpk_pkg::*;

  logic       valid_q;
  msgpk_enc_t enc_d, enc_q;
  logic [63:0] v;

  assign v = cls_i.value;

  // Format select
  always_comb begin
    enc_d = '0;
    unique case (cls_i.func)
      FN_NIL: begin
        enc_d.bytes[BufW-1 -: 8] = TAG_NIL;
        enc_d.len = 4'd1;
      end
      FN_BOOL: begin
        enc_d.bytes[BufW-1 -: 8] = cls_i.nz ? TAG_TRUE : TAG_FALSE;
        enc_d.len = 4'd1;
      end
      FN_UINT: begin
        if (cls_i.u7) begin
          enc_d.bytes[BufW-1 -: 8] = v[7:0];
          enc_d.len = 4'd1;
        end else if (cls_i.u8) begin
          enc_d.bytes[BufW-1 -: 16] = {TAG_U8, v[7:0]};
          enc_d.len = 4'd2;
        end else if (cls_i.u16) begin
          enc_d.bytes[BufW-1 -: 24] = {TAG_U16, v[15:0]};
          enc_d.len = 4'd3;
        end else if (cls_i.u32) begin
          enc_d.bytes[BufW-1 -: 40] = {TAG_U32, v[31:0]};
          enc_d.len = 4'd5;
        end else begin
          enc_d.bytes[BufW-1 -: 72] = {TAG_U64, v};
          enc_d.len = 4'd9;
        end
      end
      FN_SINT: begin
        if (cls_i.s_fix) begin
          enc_d.bytes[BufW-1 -: 8] = v[7:0];
          enc_d.len = 4'd1;
        end else if (cls_i.s8) begin
          enc_d.bytes[BufW-1 -: 16] = {TAG_I8, v[7:0]};
          enc_d.len = 4'd2;
        end else if (cls_i.s16) begin
          enc_d.bytes[BufW-1 -: 24] = {TAG_I16, v[15:0]};
          enc_d.len = 4'd3;
        end else if (cls_i.s32) begin
          enc_d.bytes[BufW-1 -: 40] = {TAG_I32, v[31:0]};
          enc_d.len = 4'd5;
        end else begin
          enc_d.bytes[BufW-1 -: 72] = {TAG_I64, v};
          enc_d.len = 4'd9;
        end
      end
      FN_F32: begin
        enc_d.bytes[BufW-1 -: 40] = {TAG_F32, v[31:0]};
        enc_d.len = 4'd5;
      end
      FN_F64: begin
        enc_d.bytes[BufW-1 -: 72] = {TAG_F64, v};
        enc_d.len = 4'd9;
      end
      FN_STR: begin
        if (cls_i.u5) begin
          enc_d.bytes[BufW-1 -: 8] = TAG_FIXSTR | v[7:0];
          enc_d.len = 4'd1;
        end else if (cls_i.u8) begin
          enc_d.bytes[BufW-1 -: 16] = {TAG_STR8, v[7:0]};
          enc_d.len = 4'd2;
        end else if (cls_i.u16) begin
          enc_d.bytes[BufW-1 -: 24] = {TAG_STR16, v[15:0]};
          enc_d.len = 4'd3;
        end else if (cls_i.u32) begin
          enc_d.bytes[BufW-1 -: 40] = {TAG_STR32, v[31:0]};
          enc_d.len = 4'd5;
        end else begin
          enc_d.len = 4'd1;
          enc_d.err = 1'b1;
        end
      end
      FN_BIN: begin
        if (cls_i.u8) begin
          enc_d.bytes[BufW-1 -: 16] = {TAG_BIN8, v[7:0]};
          enc_d.len = 4'd2;
        end else if (cls_i.u16) begin
          enc_d.bytes[BufW-1 -: 24] = {TAG_BIN16, v[15:0]};
          enc_d.len = 4'd3;
        end else if (cls_i.u32) begin
          enc_d.bytes[BufW-1 -: 40] = {TAG_BIN32, v[31:0]};
          enc_d.len = 4'd5;
        end else begin
          enc_d.len = 4'd1;
          enc_d.err = 1'b1;
        end
      end
      FN_ARRAY, FN_MAP: begin
        if (cls_i.u4) begin
          enc_d.bytes[BufW-1 -: 8] =
            ((cls_i.func == FN_MAP) ? TAG_FIXMAP : TAG_FIXARR) | v[7:0];
          enc_d.len = 4'd1;
        end else if (cls_i.u16) begin
          enc_d.bytes[BufW-1 -: 24] =
            {(cls_i.func == FN_MAP) ? TAG_MAP16 : TAG_ARR16, v[15:0]};
          enc_d.len = 4'd3;
        end else if (cls_i.u32) begin
          enc_d.bytes[BufW-1 -: 40] =
            {(cls_i.func == FN_MAP) ? TAG_MAP32 : TAG_ARR32, v[31:0]};
          enc_d.len = 4'd5;
        end else begin
          enc_d.len = 4'd1;
          enc_d.err = 1'b1;
        end
      end
      FN_TS: begin
        if (cls_i.ts_small && cls_i.ts_32) begin
          enc_d.bytes[BufW-1 -: 48] = {TAG_FIXEXT4, TS_TYPE, v[31:0]};
          enc_d.len = 4'd6;
        end else if (cls_i.ts_small) begin
          enc_d.bytes[BufW-1 -: 80] = {TAG_FIXEXT8, TS_TYPE, cls_i.ns[29:0], v[33:0]};
          enc_d.len = 4'd10;
        end else begin
          enc_d.bytes = {TAG_EXT8, TS96_LEN, TS_TYPE, v, cls_i.ns};
          enc_d.len = 4'd15;
        end
      end
      FN_RAW: begin
        enc_d.bytes[BufW-1 -: 8] = v[7:0];
        enc_d.len = 4'd1;
      end
      default: begin
        // unused codes give no result
        enc_d.len = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      enc_q <= enc_d;
    end
  end

  assign valid_o = valid_q;
  assign enc_o   = enc_q;

endmodule

FILE: design/msgpk_serial.sv
// ----------------------------------------------------------------------------
// msgpk_serial
// Third stage: shifts the encoded bytes out, one per cycle, first byte first.
// ----------------------------------------------------------------------------
module msgpk_serial (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  msgpk_pkg::msgpk_enc_t enc_i,
  output logic                  ready_o,
  output logic                  strobe_o,
  output logic [7:0]            out_byte_o,
  output logic                  last_o,
  output logic                  size_error_o
);
  import msgpk_pkg::*;

  logic [3:0]      count_q;
  logic [BufW-1:0] buf_q;
  logic            err_q;

  // free once the final byte is on the port
  assign ready_o = (count_q <= 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
    end else if (ready_o) begin
      count_q <= valid_i ? enc_i.len : 4'd0;
    end else begin
      count_q <= count_q - 4'd1;
    end
  end

  // byte buffer and error flag
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      buf_q <= enc_i.bytes;
      err_q <= enc_i.err;
    end else begin
      buf_q <= {buf_q[BufW-9:0], 8'h00};
    end
  end

  assign strobe_o     = (count_q != 4'd0);
  assign out_byte_o   = buf_q[BufW-1 -: 8];
  assign last_o       = (count_q == 4'd1);
  assign size_error_o = strobe_o && err_q;

endmodule
